// File: rtl/inverse_cdf_table_sampler_assert.svh
// assertion macros shared by the sampler rtl
`ifndef INVERSE_CDF_TABLE_SAMPLER_ASSERT_SVH
`define INVERSE_CDF_TABLE_SAMPLER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define ICDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ICDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/icdf_pkg.sv
package icdf_pkg;

  // field widths
  localparam int SAMPLE_W   = 26;
  localparam int BIN_W      = 10;
  localparam int ENTRY_W    = 17;
  localparam int UNIF_W     = 16;
  localparam int STEP_W     = 16;
  localparam int TSIZE_W    = 11;
  localparam int IDX_W      = 10;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_W     = 16;

  // configuration register indexes
  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_STEP_SIZE  = 1'b1;

  // operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // reset values and limits
  localparam logic [TSIZE_W-1:0]  TSIZE_RESET = 11'd700;
  localparam logic [STEP_W-1:0]   STEP_RESET  = 16'd655;
  localparam logic [ENTRY_W-1:0]  FRAC_ONE    = 17'h10000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 26'h3FFFFFF;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic [UNIF_W-1:0]  num;
    logic [ENTRY_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [ENTRY_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/icdf_ram.sv
module icdf_ram
  import icdf_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [2**AW];
  logic [ENTRY_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/icdf_div.sv
module icdf_div
  import icdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(FRAC_W + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ENTRY_W:0]   rem_r;
  logic [ENTRY_W-1:0] den_r;
  logic [ENTRY_W-1:0] quot_r;
  logic               ge;
  logic [ENTRY_W:0]   rem_sub;

  // one restoring step: compare, subtract, shift
  always_comb begin
    ge      = rem_r >= {1'b0, den_r};
    rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // quotient and remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r  <= CNT_LAST;
      rem_r  <= (ENTRY_W+1)'(req.num);
      den_r  <= req.den;
      quot_r <= '0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      rem_r  <= {rem_sub[ENTRY_W-1:0], 1'b0};
      quot_r <= {quot_r[ENTRY_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// File: rtl/inverse_cdf_table_sampler.sv
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | in_operation, in_entry_index, in_entry_value,
//         |           |                   | in_uniform_value
// out     | output    | out_valid/out_stall | out_sample_value, out_bin_index,
//         |           |                   | out_beyond_table
// cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// a sample makes s search reads, s <= floor(log2(n))+1 for the clamped table size n;
// a first-entry hit then goes straight to the scale, a draw past the table reads the
// last entry, a flat bin reads the two bracketing entries, and an interpolating draw
// reads both and then waits on the divider, which yields one quotient bit a cycle
// reset is synchronous and active low; table contents are not cleared
// in_stall is high while a sample is in flight; a held result in the output register
// does not block new transactions until the next sample needs that register
`include "inverse_cdf_table_sampler_assert.svh"

module inverse_cdf_table_sampler
  import icdf_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [IDX_W-1:0]      in_entry_index,
  input  logic [ENTRY_W-1:0]    in_entry_value,
  input  logic [UNIF_W-1:0]     in_uniform_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SAMPLE_W-1:0]   out_sample_value,
  output logic [BIN_W-1:0]      out_bin_index,
  output logic                  out_beyond_table,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int NW  = $clog2(TABLE_DEPTH + 1);
  localparam int SW  = (NW > TSIZE_W) ? NW : TSIZE_W;
  localparam int XW  = (NW > IDX_W) ? NW : IDX_W;
  localparam int AVW = NW + ENTRY_W;
  localparam int PW  = STEP_W + AVW;
  localparam int SHW = PW - FRAC_W;
  localparam int EW  = (SHW > SAMPLE_W) ? SHW : SAMPLE_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SEARCH = 7'b0000010,
    ST_BELOW  = 7'b0000100,
    ST_ABOVE  = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_LAST   = 7'b0100000,
    ST_MUL    = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [TSIZE_W-1:0]   table_size_r;
  logic [STEP_W-1:0]    step_size_r;
  logic [UNIF_W-1:0]    u_r, u_nxt;
  logic [NW-1:0]        lo_r, lo_nxt;
  logic [NW-1:0]        hi_r, hi_nxt;
  logic [NW-1:0]        mid_r, mid_nxt;
  logic [ENTRY_W-1:0]   below_r, below_nxt;
  logic [AVW-1:0]       a_r, a_nxt;
  logic [BIN_W-1:0]     bin_r, bin_nxt;
  logic                 beyond_r, beyond_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]  out_sample_r;
  logic [BIN_W-1:0]     out_bin_r;
  logic                 out_beyond_r;

  logic                 in_acc;
  logic                 out_free;
  logic [SW-1:0]        ts_ext;
  logic [NW-1:0]        n;
  logic [NW-1:0]        n_m1;
  logic                 wr_ok;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [ENTRY_W-1:0]   rd_data;
  logic                 lt;
  logic [NW-1:0]        lo_s, hi_s, mid_s;
  logic [NW:0]          sum_s;
  logic [ENTRY_W-1:0]   u_diff;
  logic [ENTRY_W-1:0]   frac;
  logic [AVW-1:0]       pos_base;
  logic [PW-1:0]        prod;
  logic [EW-1:0]        prod_ext;
  logic [SAMPLE_W-1:0]  sample;
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic                 sample_acc;
  logic                 last_bin_ok;

  // handshake
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // effective table size clamped to [2, TABLE_DEPTH]
  always_comb begin
    ts_ext = SW'(table_size_r);
    if (ts_ext < SW'(2)) begin
      n = NW'(2);
    end else if (ts_ext > SW'(TABLE_DEPTH)) begin
      n = NW'(TABLE_DEPTH);
    end else begin
      n = NW'(ts_ext);
    end
    n_m1 = n - 1'b1;
  end

  // table writes beyond the depth are dropped
  assign wr_ok = XW'(in_entry_index) < XW'(TABLE_DEPTH);

  icdf_ram #(
    .AW (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (in_acc && in_operation == OP_WRITE && wr_ok),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (in_entry_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  icdf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // one binary search step on the entry just read
  always_comb begin
    lt    = rd_data < {1'b0, u_r};
    lo_s  = lt ? (mid_r + 1'b1) : lo_r;
    hi_s  = lt ? hi_r : mid_r;
    sum_s = {1'b0, lo_s} + {1'b0, hi_s};
    mid_s = sum_s[NW:1];
  end

  // interpolation operands
  always_comb begin
    u_diff   = {1'b0, u_r} - below_r;
    frac     = (div_rsp.quot > FRAC_ONE) ? FRAC_ONE : div_rsp.quot;
    pos_base = AVW'(lo_r - 1'b1) << FRAC_W;
  end

  // final scale by step size with saturation
  always_comb begin
    prod     = PW'(step_size_r) * PW'(a_r);
    prod_ext = EW'(prod[PW-1:FRAC_W]);
    sample   = (prod_ext > EW'(SAMPLE_MAX)) ? SAMPLE_MAX : SAMPLE_W'(prod_ext);
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    u_nxt       = u_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    below_nxt   = below_r;
    a_nxt       = a_r;
    bin_nxt     = bin_r;
    beyond_nxt  = beyond_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    div_req     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_operation == OP_SAMPLE) begin
          u_nxt     = in_uniform_value;
          lo_nxt    = '0;
          hi_nxt    = n;
          mid_nxt   = n >> 1;
          rd_en     = 1'b1;
          rd_addr   = AW'(n >> 1);
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        lo_nxt = lo_s;
        hi_nxt = hi_s;
        if (lo_s < hi_s) begin
          mid_nxt = mid_s;
          rd_en   = 1'b1;
          rd_addr = AW'(mid_s);
        end else if (lo_s >= n) begin
          // no entry reached u
          rd_en     = 1'b1;
          rd_addr   = AW'(n_m1);
          state_nxt = ST_LAST;
        end else if (lo_s == '0) begin
          // first entry qualifies
          a_nxt      = '0;
          bin_nxt    = '0;
          beyond_nxt = 1'b0;
          state_nxt  = ST_MUL;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(lo_s - 1'b1);
          state_nxt = ST_BELOW;
        end
      end
      ST_BELOW: begin
        below_nxt = rd_data;
        rd_en     = 1'b1;
        rd_addr   = AW'(lo_r);
        state_nxt = ST_ABOVE;
      end
      ST_ABOVE: begin
        bin_nxt    = BIN_W'(lo_r);
        beyond_nxt = 1'b0;
        if (rd_data > below_r && {1'b0, u_r} > below_r) begin
          div_req.start = 1'b1;
          div_req.num   = u_diff[UNIF_W-1:0];
          div_req.den   = rd_data - below_r;
          state_nxt     = ST_DIV;
        end else begin
          // flat bin: take the full bin width
          a_nxt     = pos_base + AVW'(FRAC_ONE);
          state_nxt = ST_MUL;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          a_nxt     = pos_base + AVW'(frac);
          state_nxt = ST_MUL;
        end
      end
      ST_LAST: begin
        a_nxt      = AVW'(n_m1) * AVW'(rd_data);
        bin_nxt    = BIN_W'(n_m1);
        beyond_nxt = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == ST_MUL && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      table_size_r <= TSIZE_RESET;
      step_size_r  <= STEP_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TABLE_SIZE: table_size_r <= cfg_data[TSIZE_W-1:0];
          CFG_STEP_SIZE:  step_size_r  <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    u_r      <= u_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    below_r  <= below_nxt;
    a_r      <= a_nxt;
    bin_r    <= bin_nxt;
    beyond_r <= beyond_nxt;
    if (state_r == ST_MUL && out_free) begin
      out_sample_r <= sample;
      out_bin_r    <= bin_r;
      out_beyond_r <= beyond_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_sample_r;
  assign out_bin_index    = out_bin_r;
  assign out_beyond_table = out_beyond_r;

  // checks
  assign sample_acc  = in_acc && in_operation == OP_SAMPLE;
  assign last_bin_ok = !out_beyond_table || out_bin_index == BIN_W'(n_m1);

  `ICDF_ASSERT_NXT(a_sample_holds_input, clk, rst_n, sample_acc, in_stall, "sample not stalled")
  `ICDF_ASSERT_IMP(a_div_done_in_div, clk, rst_n, div_rsp.done, state_r == ST_DIV, "early divide")
  `ICDF_ASSERT_IMP(a_beyond_last_bin, clk, rst_n, out_valid, last_bin_ok, "beyond-table bin")

endmodule

// File: test/inverse_cdf_table_sampler_tb.sv
module inverse_cdf_table_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import icdf_pkg::*;

  localparam int DEPTH        = 1024;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 150;
  localparam int CALM_FIRST   = 1400;
  localparam int CALM_LAST    = 1560;

  // one sampler result
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [BIN_W-1:0]    bin;
    logic                beyond;
  } draw_t;

  // one directed stimulus row, typed rows carry their own expected draw
  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] value;
    logic [UNIF_W-1:0]  u;
    logic               typed;
    draw_t              want;
  } row_t;

  localparam draw_t ZERO_DRAW = '0;

  localparam int NUM_ROWS = 20;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{OP_SAMPLE, 10'd0,     17'h00000, 16'h0000, 1'b1, ZERO_DRAW},
    '{OP_SAMPLE, 10'd0,     17'h00000, 16'hFFFF, 1'b0, ZERO_DRAW},
    '{OP_SAMPLE, 10'd0,     17'h00000, 16'h0001, 1'b0, ZERO_DRAW},
    '{OP_SAMPLE, 10'd0,     17'h00000, 16'h8000, 1'b0, ZERO_DRAW},
    '{OP_SAMPLE, 10'd0,     17'h00000, 16'h5555, 1'b0, ZERO_DRAW},
    '{OP_SAMPLE, 10'd0,     17'h00000, 16'hAAAA, 1'b0, ZERO_DRAW},
    '{OP_WRITE,  10'd0,     17'h1FFFF, 16'h0000, 1'b0, ZERO_DRAW},
    '{OP_SAMPLE, 10'd0,     17'h00000, 16'hFFFF, 1'b0, ZERO_DRAW},
    '{OP_SAMPLE, 10'd0,     17'h00000, 16'h0000, 1'b1, ZERO_DRAW},
    '{OP_WRITE,  10'd0,     17'h00000, 16'h0000, 1'b0, ZERO_DRAW},
    '{OP_WRITE,  10'd1023,  17'h10000, 16'h0000, 1'b0, ZERO_DRAW},
    '{OP_WRITE,  10'd699,   17'h0FFFF, 16'h0000, 1'b0, ZERO_DRAW},
    '{OP_SAMPLE, 10'd0,     17'h00000, 16'hFFFF, 1'b0, ZERO_DRAW},
    '{OP_WRITE,  10'd699,   17'h0FFFE, 16'h0000, 1'b0, ZERO_DRAW},
    '{OP_SAMPLE, 10'd0,     17'h00000, 16'hFFFF, 1'b0, ZERO_DRAW},
    '{OP_WRITE,  10'd698,   17'h0FFFE, 16'h0000, 1'b0, ZERO_DRAW},
    '{OP_SAMPLE, 10'd0,     17'h00000, 16'hFFFE, 1'b0, ZERO_DRAW},
    '{OP_WRITE,  10'h155,   17'h0AAAA, 16'h0000, 1'b0, ZERO_DRAW},
    '{OP_WRITE,  10'h2AA,   17'h15555, 16'h0000, 1'b0, ZERO_DRAW},
    '{OP_SAMPLE, 10'd0,     17'h00000, 16'h2AAA, 1'b0, ZERO_DRAW}
  };

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic                  in_operation     = OP_WRITE;
  logic [IDX_W-1:0]      in_entry_index   = '0;
  logic [ENTRY_W-1:0]    in_entry_value   = '0;
  logic [UNIF_W-1:0]     in_uniform_value = '0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic [SAMPLE_W-1:0]   out_sample_value;
  logic [BIN_W-1:0]      out_bin_index;
  logic                  out_beyond_table;
  logic                  cfg_we           = 1'b0;
  logic                  cfg_index        = CFG_TABLE_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;

  // shadow of the table and registers
  logic [ENTRY_W-1:0] cdf_copy [DEPTH];
  logic [TSIZE_W-1:0] size_reg = TSIZE_RESET;
  logic [STEP_W-1:0]  step_reg = STEP_RESET;

  draw_t       pending_draws [$];
  int          error_count  = 0;
  int          results_seen = 0;
  int          items_sent   = 0;
  logic        calm         = 1'b0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  always #5 clk = ~clk;

  inverse_cdf_table_sampler #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .in_uniform_value (in_uniform_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .out_bin_index    (out_bin_index),
    .out_beyond_table (out_beyond_table),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // table size clamped to the usable range
  function automatic int unsigned active_entries();
    int unsigned n;
    n = size_reg;
    if (n < 2) n = 2;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  // search plus linear interpolation, scaled by the bin width
  function automatic draw_t expected_draw(input logic [UNIF_W-1:0] u);
    draw_t             d;
    int unsigned       n, lo, hi, mid;
    longint unsigned   uu, below, above, frac, pos, acc, st;
    n  = active_entries();
    uu = u;
    st = step_reg;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (cdf_copy[mid] < u) lo = mid + 1;
      else hi = mid;
    end
    acc      = 0;
    d.bin    = '0;
    d.beyond = 1'b0;
    if (lo >= n) begin
      // nothing reached u: fall back to the last entry in use
      below    = cdf_copy[n - 1];
      acc      = (st * (n - 1) * below) >> 16;
      d.bin    = BIN_W'(n - 1);
      d.beyond = 1'b1;
    end else if (lo > 0) begin
      below = cdf_copy[lo - 1];
      above = cdf_copy[lo];
      frac  = FRAC_ONE;
      if (above > below && uu > below) frac = ((uu - below) << 16) / (above - below);
      if (frac > FRAC_ONE) frac = FRAC_ONE;
      pos   = (longint'(lo - 1) << 16) + frac;
      acc   = (st * pos) >> 16;
      d.bin = BIN_W'(lo);
    end
    d.sample = (acc > SAMPLE_MAX) ? SAMPLE_MAX : acc[SAMPLE_W-1:0];
    return d;
  endfunction

  // uniform values aimed at entries, their neighbors and the fallback region
  function automatic logic [UNIF_W-1:0] random_uniform();
    int unsigned n, k, top;
    n   = active_entries();
    k   = $urandom_range(n - 1);
    top = cdf_copy[n - 1];
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return UNIF_W'($urandom);
      5, 6:          return (cdf_copy[k] > 65535) ? '1 : cdf_copy[k][UNIF_W-1:0];
      7:             return (cdf_copy[k] >= 65535) ? '0 : UNIF_W'(cdf_copy[k] + 1);
      8:             return $urandom_range(1) ? '1 : '0;
      default:       return (top >= 65535) ? '1 : UNIF_W'($urandom_range(65535, top + 1));
    endcase
  endfunction

  // mostly keeps the table ordered, sometimes any 17-bit value
  function automatic logic [ENTRY_W-1:0] random_entry(input logic [IDX_W-1:0] idx);
    int unsigned lower_v, upper_v;
    lower_v = (idx == 0) ? 0 : cdf_copy[idx - 1];
    upper_v = (idx == DEPTH - 1) ? 65536 : cdf_copy[idx + 1];
    if ($urandom_range(3) != 0 && lower_v <= upper_v)
      return ENTRY_W'($urandom_range(upper_v, lower_v));
    if ($urandom_range(1)) return ENTRY_W'($urandom_range(65536));
    return ENTRY_W'($urandom);
  endfunction

  // offer one input transaction and record what it should produce
  task automatic offer(input logic op, input logic [IDX_W-1:0] idx,
                       input logic [ENTRY_W-1:0] value, input logic [UNIF_W-1:0] u,
                       input logic typed, input draw_t want);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_entry_index   <= idx;
    in_entry_value   <= value;
    in_uniform_value <= u;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    calm <= (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
    if (op == OP_WRITE) cdf_copy[idx] = value;
    else pending_draws.push_back(typed ? want : expected_draw(u));
  endtask

  // register write once the block has gone quiet
  task automatic write_register(input logic idx, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TABLE_SIZE) size_reg = data[TSIZE_W-1:0];
    else step_reg = data[STEP_W-1:0];
  endtask

  // mix of table updates and draws
  task automatic mixed_traffic(input int count);
    logic [IDX_W-1:0] idx;
    repeat (count) begin
      if ($urandom_range(99) < 30) begin
        idx = ($urandom_range(9) == 0) ? IDX_W'($urandom)
                                       : IDX_W'($urandom_range(active_entries() - 1));
        offer(OP_WRITE, idx, random_entry(idx), UNIF_W'($urandom), 1'b0, ZERO_DRAW);
      end else begin
        offer(OP_SAMPLE, IDX_W'($urandom), ENTRY_W'($urandom), random_uniform(),
              1'b0, ZERO_DRAW);
      end
    end
  endtask

  // result side: random stalls, one long hold-off, one calm stretch
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 31);
    end
  end

  // compare each result transaction with the oldest pending draw
  always @(posedge clk) begin : check_result
    draw_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_draws.size() == 0) begin
        $error("result transaction with no draw pending");
        error_count++;
      end else begin
        want = pending_draws.pop_front();
        if (out_sample_value !== want.sample) begin
          $error("sample_value: expected %0d, actual %0d", want.sample, out_sample_value);
          error_count++;
        end
        if (out_bin_index !== want.bin) begin
          $error("bin_index: expected %0d, actual %0d", want.bin, out_bin_index);
          error_count++;
        end
        if (out_beyond_table !== want.beyond) begin
          $error("beyond_table: expected %0d, actual %0d", want.beyond, out_beyond_table);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned lvl;
    int          i;
    lvl = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load a nondecreasing table into every entry
    for (i = 0; i < DEPTH; i++) begin
      if (i != 0) lvl = lvl + $urandom_range(127);
      if (lvl > 65536) lvl = 65536;
      offer(OP_WRITE, IDX_W'(i), ENTRY_W'(lvl), UNIF_W'($urandom), 1'b0, ZERO_DRAW);
    end

    // directed rows under the reset settings
    for (i = 0; i < NUM_ROWS; i++)
      offer(DIRECTED[i].op, DIRECTED[i].idx, DIRECTED[i].value, DIRECTED[i].u,
            DIRECTED[i].typed, DIRECTED[i].want);

    // full table, widest bins
    write_register(CFG_TABLE_SIZE, 16'd1024);
    write_register(CFG_STEP_SIZE, 16'hFFFF);
    mixed_traffic(250);

    // smallest table, zero bin width
    write_register(CFG_TABLE_SIZE, 16'd2);
    write_register(CFG_STEP_SIZE, 16'd0);
    mixed_traffic(80);

    // oversized table size clamps to the depth
    write_register(CFG_TABLE_SIZE, 16'hFFFF);
    write_register(CFG_STEP_SIZE, 16'd1);
    mixed_traffic(120);

    // undersized table sizes clamp to two entries
    write_register(CFG_TABLE_SIZE, 16'd1);
    write_register(CFG_STEP_SIZE, 16'h8000);
    mixed_traffic(60);
    write_register(CFG_TABLE_SIZE, 16'd0);
    write_register(CFG_STEP_SIZE, 16'h7FFF);
    mixed_traffic(30);

    // random settings
    for (i = 0; i < 4; i++) begin
      write_register(CFG_TABLE_SIZE, CFG_DATA_W'($urandom_range(1023, 3)));
      write_register(CFG_STEP_SIZE, CFG_DATA_W'($urandom_range(65535)));
      mixed_traffic(70);
    end

    // drain and report
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // overall time limit
  initial begin : watchdog
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
